FILE: src/mwpc_pkg.sv
// Shared types and constants for the masked word pattern counter.
`default_nettype none

package mwpc_pkg;

    // Field widths fixed by the stream format
    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 4;
    localparam int LENCFG_W = 5;
    localparam int COUNT_W  = 24;
    localparam int OFFSET_W = 26;

    // Packed stream widths
    localparam int S_TDATA_W = 104;  // 100 bits of fields, padded to bytes
    localparam int M_TDATA_W = 56;   // 53 bits of fields, padded to bytes

    // Command codes carried in s_tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // Saturation limit of the match counter
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Per-item control for each cell (load selects one cell; step and clear go to all)
    typedef struct packed {
        logic load;   // write this cell's pattern entry
        logic step;   // data word accepted: advance the partial bit
        logic clear;  // final word: partial bit goes back to zero
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/mwpc_cell.sv
// One pattern position: entry storage, masked compare and partial-match bit.
`default_nettype none

module mwpc_cell (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire mwpc_pkg::cell_ctrl_t   ctrl,
    input  wire                         active,      // position lies below the pattern length
    input  wire [mwpc_pkg::WORD_W-1:0]  entry_value,
    input  wire [mwpc_pkg::WORD_W-1:0]  entry_mask,
    input  wire [mwpc_pkg::WORD_W-1:0]  data_word,
    input  wire                         prev_bit,    // partial bit of the left neighbor
    output logic                        part_bit,    // registered partial bit
    output logic                        next_bit     // partial bit after this word
);

    logic [mwpc_pkg::WORD_W-1:0] value_reg;
    logic [mwpc_pkg::WORD_W-1:0] mask_reg;
    logic                        part_reg;
    logic                        part_next;
    logic                        eq;

    // Pattern entry storage, undefined until loaded
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            value_reg <= entry_value;
            mask_reg  <= entry_mask;
        end
    end

    // Masked compare and shift-and step
    always_comb
    begin
        eq        = ((data_word & mask_reg) == (value_reg & mask_reg));
        next_bit  = prev_bit & eq & active;
        part_next = part_reg;
        if (ctrl.step)
        begin
            part_next = ctrl.clear ? 1'b0 : next_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= 1'b0;
        end
        else
        begin
            part_reg <= part_next;
        end
    end

    assign part_bit = part_reg;

endmodule

`default_nettype wire

FILE: src/masked_word_pattern_counter.sv
// Top level: masked multi-word pattern search over a stream of image words.
// A result item is registered and shows in the cycle after its input is accepted.
// Throughput: one item per cycle unless m_tready stalls; the cell row updates every
// partial bit in the same cycle, and the output register frees once m_tready takes it.
// Reset: partial bits, scan counters and pattern length (to 1) clear at once;
// pattern entries stay undefined until loaded.
`default_nettype none

module masked_word_pattern_counter #(
    parameter int MAX_PATTERN_WORDS = 16,
    parameter int POSITION_BITS     = 24
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // Configuration: pattern_length
    input  wire                                  cfg_wr_en,
    input  wire  [mwpc_pkg::LENCFG_W-1:0]        cfg_wr_data,
    // Input stream
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // entry_index[3:0], entry_value[35:4], entry_mask[67:36], data_word[99:68], pad
    input  wire  [mwpc_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire                                  s_tuser,   // cmd
    input  wire                                  s_tlast,   // final_word
    // Output stream
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // matched_here[0], match_count[24:1], first_found[25],
    // first_byte_offset[51:26], position_overflow[52], pad
    output logic [mwpc_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast    // scan_done
);

    localparam int LEN_W = $clog2(MAX_PATTERN_WORDS + 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // Unpacked input fields
    logic [mwpc_pkg::INDEX_W-1:0] entry_index;
    logic [mwpc_pkg::WORD_W-1:0]  entry_value;
    logic [mwpc_pkg::WORD_W-1:0]  entry_mask;
    logic [mwpc_pkg::WORD_W-1:0]  data_word;

    assign entry_index = s_tdata[3:0];
    assign entry_value = s_tdata[35:4];
    assign entry_mask  = s_tdata[67:36];
    assign data_word   = s_tdata[99:68];

    // Handshake
    logic in_acc;
    logic is_data;
    logic is_load;

    assign s_tready = !m_tvalid || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign is_data  = in_acc && (s_tuser == mwpc_pkg::CMD_DATA);
    assign is_load  = in_acc && (s_tuser == mwpc_pkg::CMD_LOAD);

    // Pattern length register
    logic [mwpc_pkg::LENCFG_W-1:0] len_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= mwpc_pkg::LENCFG_W'(1);
        end
        else if (cfg_wr_en)
        begin
            len_cfg_reg <= cfg_wr_data;
        end
    end

    // Clamp length into 1..MAX_PATTERN_WORDS
    logic [LEN_W-1:0] act_len;

    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            act_len = LEN_W'(1);
        end
        else if (32'(len_cfg_reg) > 32'(MAX_PATTERN_WORDS))
        begin
            act_len = LEN_W'(MAX_PATTERN_WORDS);
        end
        else
        begin
            act_len = LEN_W'(len_cfg_reg);
        end
    end

    // Row of cells
    logic [MAX_PATTERN_WORDS-1:0] part_vec;
    logic [MAX_PATTERN_WORDS-1:0] next_vec;
    logic [MAX_PATTERN_WORDS-1:0] last_vec;

    for (genvar i = 0; i < MAX_PATTERN_WORDS; i++)
    begin : g_cell
        mwpc_pkg::cell_ctrl_t ctrl;
        logic                 prev;

        assign ctrl.load  = is_load && (32'(entry_index) == i);
        assign ctrl.step  = is_data;
        assign ctrl.clear = s_tlast;
        assign last_vec[i] = (act_len == LEN_W'(i + 1));

        if (i == 0)
        begin : g_head
            assign prev = 1'b1;
        end
        else
        begin : g_link
            assign prev = part_vec[i-1];
        end

        mwpc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .active      (act_len > LEN_W'(i)),
            .entry_value (entry_value),
            .entry_mask  (entry_mask),
            .data_word   (data_word),
            .prev_bit    (prev),
            .part_bit    (part_vec[i]),
            .next_bit    (next_vec[i])
        );
    end

    // Scan counters
    logic [POSITION_BITS-1:0]      word_pos_reg,   word_pos_next;
    logic [mwpc_pkg::COUNT_W-1:0]  count_reg,      count_next;
    logic [POSITION_BITS-1:0]      first_pos_reg,  first_pos_next;
    logic                          first_seen_reg, first_seen_next;
    logic                          ovf_reg,        ovf_next;

    // Values after this word, shown in the result
    logic                          hit;
    logic [mwpc_pkg::COUNT_W-1:0]  count_upd;
    logic [POSITION_BITS-1:0]      first_pos_upd;
    logic                          first_seen_upd;
    logic                          ovf_upd;
    logic [POSITION_BITS-1:0]      back;
    logic [POSITION_BITS+1:0]      off_full;

    always_comb
    begin
        hit            = is_data && |(next_vec & last_vec);
        back           = POSITION_BITS'(act_len - LEN_W'(1));
        count_upd      = count_reg;
        first_pos_upd  = first_pos_reg;
        first_seen_upd = first_seen_reg;
        ovf_upd        = ovf_reg;

        if (is_data && (word_pos_reg == POS_MAX))
        begin
            ovf_upd = 1'b1;
        end
        if (hit)
        begin
            if (!first_seen_reg)
            begin
                first_pos_upd  = (word_pos_reg >= back) ? (word_pos_reg - back) : '0;
                first_seen_upd = 1'b1;
            end
            if (count_reg != mwpc_pkg::COUNT_MAX)
            begin
                count_upd = count_reg + mwpc_pkg::COUNT_W'(1);
            end
        end

        word_pos_next   = word_pos_reg;
        count_next      = count_reg;
        first_pos_next  = first_pos_reg;
        first_seen_next = first_seen_reg;
        ovf_next        = ovf_reg;
        if (is_data)
        begin
            if (s_tlast)
            begin
                word_pos_next   = '0;
                count_next      = '0;
                first_pos_next  = '0;
                first_seen_next = 1'b0;
                ovf_next        = 1'b0;
            end
            else
            begin
                word_pos_next   = (word_pos_reg != POS_MAX) ?
                                  word_pos_reg + POSITION_BITS'(1) : word_pos_reg;
                count_next      = count_upd;
                first_pos_next  = first_pos_upd;
                first_seen_next = first_seen_upd;
                ovf_next        = ovf_upd;
            end
        end

        off_full = {first_pos_upd, 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_pos_reg   <= '0;
            count_reg      <= '0;
            first_pos_reg  <= '0;
            first_seen_reg <= 1'b0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            word_pos_reg   <= word_pos_next;
            count_reg      <= count_next;
            first_pos_reg  <= first_pos_next;
            first_seen_reg <= first_seen_next;
            ovf_reg        <= ovf_next;
        end
    end

    // Output register
    logic                          m_valid_reg;
    logic [mwpc_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                          m_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            m_data_reg <= {3'b000,
                           ovf_upd,
                           first_seen_upd ? mwpc_pkg::OFFSET_W'(off_full) : '0,
                           first_seen_upd,
                           count_upd,
                           hit};
            m_last_reg <= is_data && s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

FILE: dv/tb_masked_word_pattern_counter.sv
// Testbench for masked_word_pattern_counter: random stream traffic checked against a predictor.
module tb_masked_word_pattern_counter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PATTERN_WORDS = 16;
    localparam int POSITION_BITS     = 24;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int PHASE_ITEMS       = 100;
    localparam int PRESSURE_PHASE    = 3;
    localparam logic [POSITION_BITS-1:0] POS_LIMIT = {POSITION_BITS{1'b1}};

    // One input item, as the block sees it
    typedef struct packed {
        logic        cmd;
        logic [3:0]  index;
        logic [31:0] value;
        logic [31:0] mask;
        logic [31:0] word;
        logic        fin;
    } scan_item_t;

    // One result item
    typedef struct packed {
        logic                          hit;
        logic [mwpc_pkg::COUNT_W-1:0]  count;
        logic                          found;
        logic [mwpc_pkg::OFFSET_W-1:0] offset;
        logic                          done;
        logic                          ovf;
    } scan_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [mwpc_pkg::LENCFG_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [mwpc_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [mwpc_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tlast;

    masked_word_pattern_counter #(
        .MAX_PATTERN_WORDS(MAX_PATTERN_WORDS),
        .POSITION_BITS    (POSITION_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    scan_item_t   items_to_send[$];
    scan_result_t scan_results_due[$];
    int unsigned  mismatches = 0;
    int unsigned  cycle_count = 0;
    int unsigned  phase_no = 0;
    bit           idle_enabled = 1'b1;
    bit           sink_hold = 1'b0;
    int unsigned  send_gap = 0;
    int unsigned  take_gap = 0;

    // Predictor state
    logic [31:0]                   pat_value [MAX_PATTERN_WORDS];
    logic [31:0]                   pat_mask  [MAX_PATTERN_WORDS];
    logic [15:0]                   partial_bits = '0;
    logic [POSITION_BITS-1:0]      word_pos = '0;
    logic [mwpc_pkg::COUNT_W-1:0]  match_total = '0;
    logic [POSITION_BITS-1:0]      first_pos = '0;
    logic                          first_seen = 1'b0;
    logic                          overflow_seen = 1'b0;
    logic [mwpc_pkg::LENCFG_W-1:0] length_reg = 5'd1;

    // Stimulus-side copy of the pattern, used to build matching words
    logic [31:0] gen_value [MAX_PATTERN_WORDS];
    logic [31:0] gen_mask  [MAX_PATTERN_WORDS];
    logic [15:0] gen_loaded = '0;
    int unsigned gen_len = 1;

    // Length settings, one per phase; 0 and 31 exercise the clamping
    int unsigned len_plan [12] = '{0, 31, 2, 16, 1, 3, 8, 5, 12, 4, 7, 16};

    // Expected result for one accepted item; updates the scan state
    function automatic scan_result_t scan_step(input scan_item_t it);
        scan_result_t res;
        int unsigned len;
        logic [15:0] len_mask;
        logic [15:0] same;
        logic [POSITION_BITS-1:0] cur;
        res = '0;
        if (it.cmd == mwpc_pkg::CMD_LOAD)
        begin
            pat_value[it.index] = it.value;
            pat_mask[it.index]  = it.mask;
        end
        else
        begin
            len = (length_reg == 0) ? 1 :
                  (length_reg > MAX_PATTERN_WORDS) ? MAX_PATTERN_WORDS : length_reg;
            len_mask = 16'((33'd1 << len) - 1);
            // a word at the last position index flags overflow
            cur = word_pos;
            if (word_pos == POS_LIMIT)
                overflow_seen = 1'b1;
            same = '0;
            for (int i = 0; i < len; i++)
                same[i] = ((it.word ^ pat_value[i]) & pat_mask[i]) == 32'd0;
            partial_bits = (((partial_bits & len_mask) << 1) | 16'd1) & same & len_mask;
            res.hit = partial_bits[len-1];
            if (res.hit)
            begin
                if (!first_seen)
                begin
                    first_pos  = (cur >= len - 1) ? cur - POSITION_BITS'(len - 1) : '0;
                    first_seen = 1'b1;
                end
                if (match_total != mwpc_pkg::COUNT_MAX)
                    match_total = match_total + 1'b1;
            end
            if (word_pos != POS_LIMIT)
                word_pos = word_pos + 1'b1;
            res.done = it.fin;
        end
        res.count  = match_total;
        res.found  = first_seen;
        res.offset = first_seen ? {first_pos, 2'b00} : '0;
        res.ovf    = overflow_seen;
        // final word closes the scan
        if (it.cmd == mwpc_pkg::CMD_DATA && it.fin)
        begin
            partial_bits  = '0;
            word_pos      = '0;
            match_total   = '0;
            first_pos     = '0;
            first_seen    = 1'b0;
            overflow_seen = 1'b0;
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, field, want, got);
    endtask

    // Sender: offers items from the queue, with random gaps
    always @(posedge clk)
    begin : item_driver
        if (s_tvalid && s_tready)
            scan_results_due.push_back(scan_step(items_to_send.pop_front()));
        // an offered item stays on the bus until taken
        if (!s_tvalid || s_tready)
        begin
            if (send_gap != 0)
            begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (items_to_send.size() == 0)
                s_tvalid <= 1'b0;
            else if (idle_enabled && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 16);
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= items_to_send[0].cmd;
                s_tlast  <= items_to_send[0].fin;
                s_tdata  <= {4'b0, items_to_send[0].word, items_to_send[0].mask,
                             items_to_send[0].value, items_to_send[0].index};
            end
        end
    end

    // Receiver: checks each result item and stalls at random
    always @(posedge clk)
    begin : result_monitor
        scan_result_t want;
        if (m_tvalid && m_tready)
        begin
            if (scan_results_due.size() == 0)
                flag_mismatch("result with none expected", '0, 32'(m_tdata));
            else
            begin
                want = scan_results_due.pop_front();
                if (m_tdata[0] !== want.hit)
                    flag_mismatch("matched_here", want.hit, m_tdata[0]);
                if (m_tdata[24:1] !== want.count)
                    flag_mismatch("match_count", want.count, m_tdata[24:1]);
                if (m_tdata[25] !== want.found)
                    flag_mismatch("first_found", want.found, m_tdata[25]);
                if (m_tdata[51:26] !== want.offset)
                    flag_mismatch("first_byte_offset", want.offset, m_tdata[51:26]);
                if (m_tdata[52] !== want.ovf)
                    flag_mismatch("position_overflow", want.ovf, m_tdata[52]);
                if (m_tlast !== want.done)
                    flag_mismatch("scan_done", want.done, m_tlast);
            end
        end
        if (sink_hold)
            m_tready <= 1'b0;
        else if (take_gap != 0)
        begin
            take_gap = take_gap - 1;
            m_tready <= 1'b0;
        end
        else if (idle_enabled && $urandom_range(0, 7) == 0)
        begin
            take_gap = $urandom_range(0, 16);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Long receiver hold-off so the block fills up and stalls its input
    initial
    begin : sink_hold_off
        wait (phase_no == PRESSURE_PHASE);
        @(negedge clk);
        sink_hold = 1'b1;
        repeat (400) @(posedge clk);
        @(negedge clk);
        sink_hold = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_masked_word_pattern_counter: errors");
            $finish;
        end
    end

    task automatic push_load(input logic [3:0] idx, input logic [31:0] v,
                             input logic [31:0] m);
        scan_item_t it;
        it.cmd   = mwpc_pkg::CMD_LOAD;
        it.index = idx;
        it.value = v;
        it.mask  = m;
        it.word  = $urandom;
        it.fin   = 1'($urandom_range(0, 1));
        items_to_send.push_back(it);
        gen_value[idx]  = v;
        gen_mask[idx]   = m;
        gen_loaded[idx] = 1'b1;
    endtask

    task automatic push_data(input logic [31:0] w, input logic f);
        scan_item_t it;
        it.cmd   = mwpc_pkg::CMD_DATA;
        it.index = 4'($urandom_range(0, 15));
        it.value = $urandom;
        it.mask  = $urandom;
        it.word  = w;
        it.fin   = f;
        items_to_send.push_back(it);
    endtask

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(0, 4))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0;
            2: return $urandom;
            3: return $urandom & $urandom & $urandom;
            default: return 32'hFF << (8 * $urandom_range(0, 3));
        endcase
    endfunction

    // Word that matches pattern entry k, random in the uncompared bits
    function automatic logic [31:0] pattern_word(input int unsigned k);
        return (gen_value[k] & gen_mask[k]) | ($urandom & ~gen_mask[k]);
    endfunction

    task automatic wait_until_drained();
        while (items_to_send.size() != 0 || scan_results_due.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic set_length(input logic [mwpc_pkg::LENCFG_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        length_reg = v;
        gen_len = (v == 0) ? 1 : (v > MAX_PATTERN_WORDS) ? MAX_PATTERN_WORDS : v;
        @(negedge clk);
    endtask

    // Mostly pattern occurrences, some cut short, plus noise, reloads and scan ends
    task automatic run_phase(input int unsigned target);
        int unsigned sent;
        int unsigned span;
        logic [31:0] v;
        logic [31:0] m;
        sent = 0;
        case ($urandom_range(0, 3))
            0:
            begin
                // same entry everywhere: overlapping matches
                v = $urandom;
                m = pick_mask();
                for (int k = 0; k < gen_len; k++)
                    push_load(4'(k), v, m);
                sent += gen_len;
            end
            1:
            begin
                for (int k = 0; k < gen_len; k++)
                    push_load(4'(k), $urandom, pick_mask());
                sent += gen_len;
            end
            default: ;
        endcase
        // every entry the scan reads must have been loaded
        for (int k = 0; k < gen_len; k++)
        begin
            if (!gen_loaded[k])
            begin
                push_load(4'(k), $urandom, pick_mask());
                sent++;
            end
        end
        while (sent < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, gen_len) : gen_len;
                    for (int k = 0; k < span; k++)
                        push_data(pattern_word(k), 1'b0);
                    sent += span;
                end
                6, 7:
                begin
                    push_data($urandom, 1'b0);
                    sent++;
                end
                8:
                begin
                    push_load(4'($urandom_range(0, 15)), $urandom, pick_mask());
                    sent++;
                end
                default:
                begin
                    push_data($urandom_range(0, 1) ? pattern_word(gen_len - 1) : $urandom, 1'b1);
                    sent++;
                end
            endcase
        end
    endtask

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: one-word pattern at reset length, full and empty masks
        push_load(4'd0, 32'hA5C3_0F96, 32'hFFFF_FFFF);
        push_data(32'hA5C3_0F96, 1'b0);
        push_data(32'h0000_0000, 1'b0);
        push_data(32'hFFFF_FFFF, 1'b0);
        push_data(32'hA5C3_0F96, 1'b1);
        // empty mask matches anything
        push_load(4'd0, 32'hFFFF_FFFF, 32'h0);
        push_data(32'h0000_0000, 1'b0);
        push_data(32'hFFFF_FFFF, 1'b0);
        // reload during an open scan takes effect on the next word
        push_load(4'd0, 32'h0, 32'h0000_FFFF);
        push_data(32'hFFFF_0000, 1'b0);
        push_data(32'h0000_0001, 1'b0);
        push_data(32'h1234_0000, 1'b1);
        push_load(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_load(4'd0, 32'h0, 32'h0);
        push_data(32'hFFFF_FFFF, 1'b0);
        push_data(32'h0000_0000, 1'b1);
        wait_until_drained();

        // Random phases; length changes may land mid-scan
        for (int p = 0; p < 12; p++)
        begin
            set_length(mwpc_pkg::LENCFG_W'(len_plan[p]));
            phase_no = p;
            if (p == 11)
                idle_enabled = 1'b0;
            run_phase(PHASE_ITEMS);
            wait_until_drained();
        end

        if (mismatches == 0)
            $display("tb_masked_word_pattern_counter: clean");
        else
            $display("tb_masked_word_pattern_counter: errors");
        $finish;
    end

endmodule
